### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while rst is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg
// shared constants and types of the stereo 2x2 fir spatializer
// ----------------------------------------------------------------------------
package bmf_pkg;

   // filter length
   localparam int TAP_COUNT = 32;
   localparam int TAP_AW    = $clog2(TAP_COUNT);
   localparam int CNT_W     = $clog2(TAP_COUNT + 1);
   localparam int COEF_AW   = $clog2(2 * TAP_COUNT);

   // field widths
   localparam int ACT_W  = 2;
   localparam int SMP_W  = 16;
   localparam int COEF_W = 16;
   localparam int IDX_W  = 5;

   // memory words
   localparam int HIST_DW = 2 * SMP_W;
   localparam int COEF_DW = 4 * COEF_W;

   // arithmetic widths
   localparam int PROD_W    = SMP_W + COEF_W;
   localparam int ACC_W     = PROD_W + 1 + TAP_AW;
   localparam int RND_SHIFT = 14;

   // action codes
   localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_COEF   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_SWAP   = 2'd2;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_OUT
   } state_type;

   // sequencer to mac unit
   typedef struct packed {
      logic clear;
      logic issue;
      logic keep;
   } mac_ctl_type;

   // sequencer to memories
   typedef struct packed {
      logic               hist_we;
      logic [TAP_AW-1:0]  hist_waddr;
      logic [TAP_AW-1:0]  hist_raddr;
      logic               coef_we;
      logic [COEF_AW-1:0] coef_waddr;
      logic [COEF_AW-1:0] coef_raddr;
   } mem_ctl_type;

endpackage

### rtl/bmf_ram.sv
// ----------------------------------------------------------------------------
// bmf_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module bmf_ram #(
   parameter  int WIDTH = 16,
   parameter  int DEPTH = 32,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/bmf_mac.sv
// ----------------------------------------------------------------------------
// bmf_mac
// shared multiply-accumulate unit: four products per tap, two accumulators,
// round half up and saturate to q1.15
// ----------------------------------------------------------------------------
module bmf_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  bmf_pkg::mac_ctl_type                mac_ctl,
   input  logic [bmf_pkg::HIST_DW-1:0]         hist_q,
   input  logic [bmf_pkg::COEF_DW-1:0]         coef_q,
   output logic                                busy,
   output logic signed [bmf_pkg::SMP_W-1:0]    left_res,
   output logic signed [bmf_pkg::SMP_W-1:0]    right_res
);

   localparam int SW = bmf_pkg::SMP_W;
   localparam int CW = bmf_pkg::COEF_W;
   localparam int PW = bmf_pkg::PROD_W;
   localparam int AW = bmf_pkg::ACC_W;
   localparam int RW = AW - bmf_pkg::RND_SHIFT + 1;
   localparam int RND_HALF = 1 << (bmf_pkg::RND_SHIFT - 1);
   localparam logic signed [RW-1:0] SAT_MAX = RW'(32767);
   localparam logic signed [RW-1:0] SAT_MIN = RW'(-32768);

   logic                 iss_ff;
   logic                 keep_ff;
   logic                 prod_vld_ff;
   logic signed [PW:0]   prod_l_ff, prod_l_in;
   logic signed [PW:0]   prod_r_ff, prod_r_in;
   logic signed [AW-1:0] acc_l_ff;
   logic signed [AW-1:0] acc_r_ff;

   logic signed [SW-1:0] xl, xr;
   logic signed [CW-1:0] c_ll, c_rl, c_rr, c_lr;
   logic signed [PW-1:0] m_ll, m_rl, m_rr, m_lr;

   // round half up, then clamp
   function automatic logic signed [SW-1:0] round_sat(input logic signed [AW-1:0] acc);
      logic signed [AW:0]   biased;
      logic signed [RW-1:0] shr;
      logic signed [SW-1:0] res;
      biased = (AW+1)'(acc) + (AW+1)'(RND_HALF);
      shr    = biased[AW:bmf_pkg::RND_SHIFT];
      if (shr > SAT_MAX) begin
         res = SAT_MAX[SW-1:0];
      end else if (shr < SAT_MIN) begin
         res = SAT_MIN[SW-1:0];
      end else begin
         res = shr[SW-1:0];
      end
      return res;
   endfunction

   // unpack memory words, samples outside the filled history read as zero
   always_comb begin
      xl   = keep_ff ? hist_q[2*SW-1:SW] : '0;
      xr   = keep_ff ? hist_q[SW-1:0]    : '0;
      c_ll = coef_q[4*CW-1:3*CW];
      c_rl = coef_q[3*CW-1:2*CW];
      c_rr = coef_q[2*CW-1:CW];
      c_lr = coef_q[CW-1:0];
   end

   // four products and the pair sums
   always_comb begin
      m_ll      = xl * c_ll;
      m_rl      = xr * c_rl;
      m_rr      = xr * c_rr;
      m_lr      = xl * c_lr;
      prod_l_in = (PW+1)'(m_ll) + (PW+1)'(m_rl);
      prod_r_in = (PW+1)'(m_rr) + (PW+1)'(m_lr);
   end

   // pipeline valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff      <= 1'b0;
         keep_ff     <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         iss_ff      <= mac_ctl.issue;
         keep_ff     <= mac_ctl.keep;
         prod_vld_ff <= iss_ff;
      end
   end

   // product register
   always_ff @(posedge clock) begin
      prod_l_ff <= prod_l_in;
      prod_r_ff <= prod_r_in;
   end

   // accumulators
   always_ff @(posedge clock) begin
      if (reset || mac_ctl.clear) begin
         acc_l_ff <= '0;
         acc_r_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_l_ff <= acc_l_ff + AW'(prod_l_ff);
         acc_r_ff <= acc_r_ff + AW'(prod_r_ff);
      end
   end

   assign busy      = iss_ff | prod_vld_ff;
   assign left_res  = round_sat(acc_l_ff);
   assign right_res = round_sat(acc_r_ff);

endmodule

### rtl/bmf_seq.sv
// ----------------------------------------------------------------------------
// bmf_seq
// sequencer: decodes beats, owns the history pointers, fill count and bank,
// and steps the mac unit through the taps
// ----------------------------------------------------------------------------
module bmf_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bmf_pkg::ACT_W-1:0]     req_action,
   input  logic [bmf_pkg::IDX_W-1:0]     req_tap_index,
   input  logic                          out_free,
   input  logic                          mac_busy,
   output bmf_pkg::mem_ctl_type          mem_ctl,
   output bmf_pkg::mac_ctl_type          mac_ctl,
   output logic                          load_out
);

   localparam int TW    = bmf_pkg::TAP_AW;
   localparam int CA    = bmf_pkg::COEF_AW;
   localparam int NW    = bmf_pkg::CNT_W;
   localparam int EXT_W = bmf_pkg::IDX_W + TW;
   localparam logic [TW-1:0] LAST_TAP = TW'(bmf_pkg::TAP_COUNT - 1);

   bmf_pkg::state_type state_ff, state_in;
   logic [TW-1:0] tap_ff, tap_in;
   logic [TW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [TW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] fill_ff, fill_in;
   logic          bank_ff, bank_in;

   logic          accept;
   logic          is_sample, is_coef, is_swap;
   logic [EXT_W-1:0] idx_ext;
   logic          idx_ok;
   logic [TW-1:0] wr_ptr_nxt, rd_ptr_nxt;

   assign accept = req_valid && req_ready;

   // action decode
   always_comb begin
      is_sample = 1'b0;
      is_coef   = 1'b0;
      is_swap   = 1'b0;
      unique case (req_action)
         bmf_pkg::ACT_SAMPLE: is_sample = 1'b1;
         bmf_pkg::ACT_COEF:   is_coef   = 1'b1;
         bmf_pkg::ACT_SWAP:   is_swap   = 1'b1;
         default: ;
      endcase
   end

   // tap index range check
   assign idx_ext = EXT_W'(req_tap_index);
   assign idx_ok  = idx_ext < EXT_W'(bmf_pkg::TAP_COUNT);

   // circular pointer steps
   assign wr_ptr_nxt = (wr_ptr_ff == LAST_TAP) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_nxt = (rd_ptr_ff == LAST_TAP) ? '0 : rd_ptr_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bmf_pkg::ST_IDLE:  if (accept && is_sample) state_in = bmf_pkg::ST_RUN;
         bmf_pkg::ST_RUN:   if (tap_ff == LAST_TAP) state_in = bmf_pkg::ST_DRAIN;
         bmf_pkg::ST_DRAIN: if (!mac_busy) state_in = bmf_pkg::ST_OUT;
         bmf_pkg::ST_OUT:   if (out_free) state_in = bmf_pkg::ST_IDLE;
         default:           state_in = bmf_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready     = 1'b0;
      mac_ctl.clear = 1'b0;
      mac_ctl.issue = 1'b0;
      load_out      = 1'b0;
      // a tap sees a real sample once enough samples have arrived
      mac_ctl.keep  = ((NW+1)'(tap_ff) + (NW+1)'(fill_ff))
                      >= (NW+1)'(bmf_pkg::TAP_COUNT);
      unique case (state_ff)
         bmf_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            mac_ctl.clear = 1'b1;
         end
         bmf_pkg::ST_RUN:   mac_ctl.issue = 1'b1;
         bmf_pkg::ST_DRAIN: ;
         bmf_pkg::ST_OUT:   load_out = out_free;
         default: ;
      endcase
   end

   // memory control
   always_comb begin
      mem_ctl.hist_we    = accept && is_sample;
      mem_ctl.hist_waddr = wr_ptr_ff;
      mem_ctl.hist_raddr = rd_ptr_ff;
      mem_ctl.coef_we    = accept && is_coef && idx_ok;
      mem_ctl.coef_waddr = bank_ff ? CA'(idx_ext[TW-1:0])
                                   : CA'(idx_ext[TW-1:0]) + CA'(bmf_pkg::TAP_COUNT);
      mem_ctl.coef_raddr = bank_ff ? CA'(tap_ff) + CA'(bmf_pkg::TAP_COUNT)
                                   : CA'(tap_ff);
   end

   // counter and pointer next values
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      tap_in    = tap_ff;
      fill_in   = fill_ff;
      bank_in   = bank_ff;
      if (mem_ctl.hist_we) begin
         wr_ptr_in = wr_ptr_nxt;
         rd_ptr_in = wr_ptr_nxt;
         tap_in    = '0;
         if (fill_ff != NW'(bmf_pkg::TAP_COUNT)) begin
            fill_in = fill_ff + 1'b1;
         end
      end else if (state_ff == bmf_pkg::ST_RUN) begin
         rd_ptr_in = rd_ptr_nxt;
         tap_in    = tap_ff + 1'b1;
      end
      if (accept && is_swap) begin
         bank_in = ~bank_ff;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bmf_pkg::ST_IDLE;
         tap_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         bank_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         tap_ff    <= tap_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
         bank_ff   <= bank_in;
      end
   end

endmodule

### rtl/binaural_matrix_fir.sv
// ----------------------------------------------------------------------------
// binaural_matrix_fir
// stereo 2x2 fir spatializer with two coefficient banks
// ----------------------------------------------------------------------------
// usage
//   req_ channel carries one beat per action: a stereo sample, a coefficient
//   tap written to the inactive bank, or a bank swap. rsp_ channel returns
//   one left/right pair for each sample beat only.
//   a sample beat holds req_ready low while the sequencer steps through all
//   taps on the shared four-multiplier mac unit, flushes the ram read and
//   product registers and then rounds and loads the output register; no
//   other beat is taken until it returns to idle. coefficient and swap
//   beats are taken in idle and do not leave it. the result register holds
//   one pair; the next sample waits in its final step until rsp_ready frees
//   it, and no other beats are taken meanwhile.
//   reset empties the history (a fill count makes unwritten history read as
//   zero, no clearing pass) and selects bank zero. coefficients are not
//   cleared and must be loaded before the first sample.
// ----------------------------------------------------------------------------
module binaural_matrix_fir (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [bmf_pkg::ACT_W-1:0]            req_action,
   input  logic signed [bmf_pkg::SMP_W-1:0]     req_left_in,
   input  logic signed [bmf_pkg::SMP_W-1:0]     req_right_in,
   input  logic [bmf_pkg::IDX_W-1:0]            req_tap_index,
   input  logic signed [bmf_pkg::COEF_W-1:0]    req_coef_left_left,
   input  logic signed [bmf_pkg::COEF_W-1:0]    req_coef_right_left,
   input  logic signed [bmf_pkg::COEF_W-1:0]    req_coef_right_right,
   input  logic signed [bmf_pkg::COEF_W-1:0]    req_coef_left_right,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [bmf_pkg::SMP_W-1:0]     rsp_left_out,
   output logic signed [bmf_pkg::SMP_W-1:0]     rsp_right_out
);

   bmf_pkg::mem_ctl_type mem_ctl;
   bmf_pkg::mac_ctl_type mac_ctl;
   logic                 load_out;
   logic                 out_free;
   logic                 mac_busy;
   logic [bmf_pkg::HIST_DW-1:0] hist_q;
   logic [bmf_pkg::COEF_DW-1:0] coef_q;
   logic signed [bmf_pkg::SMP_W-1:0] left_res, right_res;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [bmf_pkg::SMP_W-1:0] rsp_left_ff;
   logic signed [bmf_pkg::SMP_W-1:0] rsp_right_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // sequencer
   bmf_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_tap_index (req_tap_index),
      .out_free      (out_free),
      .mac_busy      (mac_busy),
      .mem_ctl       (mem_ctl),
      .mac_ctl       (mac_ctl),
      .load_out      (load_out)
   );

   // sample history, left in the upper half
   bmf_ram #(
      .WIDTH (bmf_pkg::HIST_DW),
      .DEPTH (bmf_pkg::TAP_COUNT)
   ) u_hist_ram (
      .clock (clock),
      .we    (mem_ctl.hist_we),
      .waddr (mem_ctl.hist_waddr),
      .wdata ({req_left_in, req_right_in}),
      .raddr (mem_ctl.hist_raddr),
      .rdata (hist_q)
   );

   // coefficient banks, all four filters side by side
   bmf_ram #(
      .WIDTH (bmf_pkg::COEF_DW),
      .DEPTH (2 * bmf_pkg::TAP_COUNT)
   ) u_coef_ram (
      .clock (clock),
      .we    (mem_ctl.coef_we),
      .waddr (mem_ctl.coef_waddr),
      .wdata ({req_coef_left_left, req_coef_right_left,
               req_coef_right_right, req_coef_left_right}),
      .raddr (mem_ctl.coef_raddr),
      .rdata (coef_q)
   );

   // shared mac unit
   bmf_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .mac_ctl   (mac_ctl),
      .hist_q    (hist_q),
      .coef_q    (coef_q),
      .busy      (mac_busy),
      .left_res  (left_res),
      .right_res (right_res)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_left_ff  <= left_res;
         rsp_right_ff <= right_res;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

endmodule

### rtl/bmf_checker.sv
// ----------------------------------------------------------------------------
// bmf_checker
// port-level checks of the spatializer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [bmf_pkg::ACT_W-1:0]         req_action,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [bmf_pkg::SMP_W-1:0]  rsp_left_out,
   input logic signed [bmf_pkg::SMP_W-1:0]  rsp_right_out
);

   logic                           req_beat;
   logic                           sample_beat;
   logic                           rsp_stall;
   logic [2*bmf_pkg::SMP_W-1:0]    rsp_data;

   // handshake shorthands
   assign req_beat    = req_valid && req_ready;
   assign sample_beat = req_beat && (req_action == bmf_pkg::ACT_SAMPLE);
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_data    = {rsp_left_out, rsp_right_out};

   // a stalled result beat stays offered
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid, "rsp beat dropped")

   // a stalled result beat keeps its payload
   `ASSERT_CLK(a_rsp_stable, clock, reset, rsp_stall |=> $stable(rsp_data), "rsp payload moved")

   // a sample beat occupies the block on the following cycle
   `ASSERT_CLK(a_sample_busy, clock, reset, sample_beat |=> !req_ready, "ready after sample")

   // no result follows a reset cycle
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp valid right after reset")

   // a fresh result never directly follows an accepted request beat
   `ASSERT_CLK(a_rsp_not_early, clock, reset, $rose(rsp_valid) |-> !$past(req_beat), "early rsp")

endmodule

bind binaural_matrix_fir bmf_checker u_bmf_checker (.*);

### verif/stereo_fir_check_pkg.sv
// ----------------------------------------------------------------------------
// stereo_fir_check_pkg
// beat type and scoreboard for the stereo 2x2 fir spatializer bench
// ----------------------------------------------------------------------------
// the scoreboard keeps its own copy of both delay lines and of both
// coefficient banks. every accepted sample, coefficient or swap beat updates
// that copy, and a sample beat queues the left/right pair that the block must return.
// ----------------------------------------------------------------------------
package stereo_fir_check_pkg;
   import bmf_pkg::*;

   // one request beat
   typedef struct {
      logic [ACT_W-1:0]          action;
      logic signed [SMP_W-1:0]   left_in;
      logic signed [SMP_W-1:0]   right_in;
      logic [IDX_W-1:0]          tap_index;
      logic signed [COEF_W-1:0]  coef_ll;
      logic signed [COEF_W-1:0]  coef_rl;
      logic signed [COEF_W-1:0]  coef_rr;
      logic signed [COEF_W-1:0]  coef_lr;
   } fir_beat_t;

   // one response beat
   typedef struct {
      logic signed [SMP_W-1:0] left_out;
      logic signed [SMP_W-1:0] right_out;
   } stereo_pair_t;

   class stereo_fir_scoreboard;
      logic signed [SMP_W-1:0]  hist_left [TAP_COUNT];
      logic signed [SMP_W-1:0]  hist_right [TAP_COUNT];
      logic signed [COEF_W-1:0] tap_ll [2][TAP_COUNT];
      logic signed [COEF_W-1:0] tap_rl [2][TAP_COUNT];
      logic signed [COEF_W-1:0] tap_rr [2][TAP_COUNT];
      logic signed [COEF_W-1:0] tap_lr [2][TAP_COUNT];
      logic                     live_bank;
      stereo_pair_t             expected_pairs [$];
      int                       errors;

      function new();
         int t;
         for (t = 0; t < TAP_COUNT; t++) begin
            hist_left[t] = '0;
            hist_right[t] = '0;
            tap_ll[0][t] = '0;
            tap_ll[1][t] = '0;
            tap_rl[0][t] = '0;
            tap_rl[1][t] = '0;
            tap_rr[0][t] = '0;
            tap_rr[1][t] = '0;
            tap_lr[0][t] = '0;
            tap_lr[1][t] = '0;
         end
         live_bank = 1'b0;
         errors = 0;
      endfunction

      // one line per mismatch, quiet after the first few dozen
      function void report(string msg);
         errors++;
         if (errors <= 40) begin
            $display("[%0t] mismatch: %s", $time, msg);
         end
      endfunction

      // q3.29 sum to q1.15, round half up, then clamp
      function logic signed [SMP_W-1:0] round_to_q15(longint acc);
         longint r;
         r = (acc + longint'(8192)) >>> 14;
         if (r > 32767) begin
            r = 32767;
         end else if (r < -32768) begin
            r = -32768;
         end
         return r[SMP_W-1:0];
      endfunction

      // shift one stereo sample in and run the 2x2 matrix over the live bank
      function stereo_pair_t mix_sample(logic signed [SMP_W-1:0] left,
                                        logic signed [SMP_W-1:0] right);
         longint       acc_l;
         longint       acc_r;
         stereo_pair_t pair;
         int           t;
         for (t = 0; t < TAP_COUNT - 1; t++) begin
            hist_left[t] = hist_left[t+1];
            hist_right[t] = hist_right[t+1];
         end
         hist_left[TAP_COUNT-1] = left;
         hist_right[TAP_COUNT-1] = right;
         acc_l = 0;
         acc_r = 0;
         for (t = 0; t < TAP_COUNT; t++) begin
            acc_l += longint'(hist_left[t]) * longint'(tap_ll[live_bank][t])
                   + longint'(hist_right[t]) * longint'(tap_rl[live_bank][t]);
            acc_r += longint'(hist_right[t]) * longint'(tap_rr[live_bank][t])
                   + longint'(hist_left[t]) * longint'(tap_lr[live_bank][t]);
         end
         pair.left_out = round_to_q15(acc_l);
         pair.right_out = round_to_q15(acc_r);
         return pair;
      endfunction

      // accepted request beat
      function void note_beat(fir_beat_t beat);
         logic spare;
         spare = ~live_bank;
         case (beat.action)
            ACT_COEF: begin
               if (beat.tap_index < TAP_COUNT) begin
                  tap_ll[spare][beat.tap_index] = beat.coef_ll;
                  tap_rl[spare][beat.tap_index] = beat.coef_rl;
                  tap_rr[spare][beat.tap_index] = beat.coef_rr;
                  tap_lr[spare][beat.tap_index] = beat.coef_lr;
               end
            end
            ACT_SWAP: begin
               live_bank = spare;
            end
            ACT_SAMPLE: begin
               expected_pairs.push_back(mix_sample(beat.left_in, beat.right_in));
            end
            default: begin
               // reserved action, ignored by the block
            end
         endcase
      endfunction

      // accepted response beat against the oldest queued pair
      function void check_pair(logic signed [SMP_W-1:0] left,
                               logic signed [SMP_W-1:0] right);
         stereo_pair_t want;
         if (expected_pairs.size() == 0) begin
            report($sformatf("response %0d/%0d with nothing queued", left, right));
         end else begin
            want = expected_pairs.pop_front();
            if (left !== want.left_out) begin
               report($sformatf("left_out %0d, expected %0d", left, want.left_out));
            end
            if (right !== want.right_out) begin
               report($sformatf("right_out %0d, expected %0d", right, want.right_out));
            end
         end
      endfunction

      function int pending();
         return expected_pairs.size();
      endfunction
   endclass

endpackage

### verif/binaural_matrix_fir_test.sv
// ----------------------------------------------------------------------------
// binaural_matrix_fir_test
// self-checking bench for the stereo 2x2 fir spatializer
// ----------------------------------------------------------------------------
// loads both coefficient banks, then runs a short directed sequence (round
// half cases, saturation both ways, reserved action, tap writes at both ends
// of the index range, bank swaps) followed by random traffic: mostly samples,
// with single tap writes, whole bank reloads and swaps mixed in. requests
// come in bursts with random gaps and the response side stalls on its own
// pattern. every response pair is compared with the scoreboard's prediction.
// ----------------------------------------------------------------------------
module binaural_matrix_fir_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bmf_pkg::*;
   import stereo_fir_check_pkg::*;

   // action code the block must ignore
   localparam logic [ACT_W-1:0] ACT_RESERVED = 2'd3;

   localparam int RANDOM_BEATS  = 1250;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = TAP_COUNT + 16;

   // value ranges for samples and coefficients
   typedef enum {SPAN_WIDE, SPAN_NARROW, SPAN_RAIL} span_e;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [ACT_W-1:0]          req_action = ACT_SAMPLE;
   logic signed [SMP_W-1:0]   req_left_in = '0;
   logic signed [SMP_W-1:0]   req_right_in = '0;
   logic [IDX_W-1:0]          req_tap_index = '0;
   logic signed [COEF_W-1:0]  req_coef_left_left = '0;
   logic signed [COEF_W-1:0]  req_coef_right_left = '0;
   logic signed [COEF_W-1:0]  req_coef_right_right = '0;
   logic signed [COEF_W-1:0]  req_coef_left_right = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [SMP_W-1:0]   rsp_left_out;
   logic signed [SMP_W-1:0]   rsp_right_out;

   stereo_fir_scoreboard sb;
   int                   burst_left = 0;
   int                   beats_sent = 0;
   int                   quiet_cycles = 0;
   int                   ready_hold = 0;
   bit                   drained_once = 1'b0;

   binaural_matrix_fir dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_left_in          (req_left_in),
      .req_right_in         (req_right_in),
      .req_tap_index        (req_tap_index),
      .req_coef_left_left   (req_coef_left_left),
      .req_coef_right_left  (req_coef_right_left),
      .req_coef_right_right (req_coef_right_right),
      .req_coef_left_right  (req_coef_left_right),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_left_out         (rsp_left_out),
      .rsp_right_out        (rsp_right_out)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // weighted choice of value range
   function automatic span_e pick_span(int wide_pct, int rail_pct);
      int roll = $urandom_range(0, 99);
      if (roll < rail_pct) begin
         return SPAN_RAIL;
      end else if (roll < rail_pct + wide_pct) begin
         return SPAN_WIDE;
      end
      return SPAN_NARROW;
   endfunction

   function automatic logic signed [SMP_W-1:0] draw_value(span_e span);
      case (span)
         SPAN_NARROW: return SMP_W'($signed($urandom_range(0, 2047)) - 1024);
         SPAN_RAIL:   return ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
         default:     return SMP_W'($urandom);
      endcase
   endfunction

   // every field random, unused ones included
   function automatic fir_beat_t random_beat(logic [ACT_W-1:0] action);
      fir_beat_t b;
      b.action = action;
      b.left_in = SMP_W'($urandom);
      b.right_in = SMP_W'($urandom);
      b.tap_index = IDX_W'($urandom);
      b.coef_ll = COEF_W'($urandom);
      b.coef_rl = COEF_W'($urandom);
      b.coef_rr = COEF_W'($urandom);
      b.coef_lr = COEF_W'($urandom);
      return b;
   endfunction

   // one request beat; bursts of random length, random gaps between them
   task automatic push_beat(input fir_beat_t b);
      req_valid <= 1'b1;
      req_action <= b.action;
      req_left_in <= b.left_in;
      req_right_in <= b.right_in;
      req_tap_index <= b.tap_index;
      req_coef_left_left <= b.coef_ll;
      req_coef_right_left <= b.coef_rl;
      req_coef_right_right <= b.coef_rr;
      req_coef_left_right <= b.coef_lr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_beat(b);
      if (b.action != ACT_RESERVED) begin
         beats_sent++;
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 8);
         repeat ($urandom_range(1, 50)) @(posedge clock);
      end
   endtask

   task automatic play_sample(input logic signed [SMP_W-1:0] left,
                              input logic signed [SMP_W-1:0] right);
      fir_beat_t b;
      b = random_beat(ACT_SAMPLE);
      b.left_in = left;
      b.right_in = right;
      push_beat(b);
   endtask

   task automatic write_tap(input logic [IDX_W-1:0] idx, input span_e span);
      fir_beat_t b;
      b = random_beat(ACT_COEF);
      b.tap_index = idx;
      b.coef_ll = draw_value(span);
      b.coef_rl = draw_value(span);
      b.coef_rr = draw_value(span);
      b.coef_lr = draw_value(span);
      push_beat(b);
   endtask

   task automatic swap_banks();
      push_beat(random_beat(ACT_SWAP));
   endtask

   // fill every tap of the inactive bank
   task automatic load_bank(input span_e span);
      int t;
      for (t = 0; t < TAP_COUNT; t++) begin
         write_tap(IDX_W'(t), span);
      end
   endtask

   // drop valid and hold off until every queued pair has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // response side: check, then run the stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            sb.check_pair(rsp_left_out, rsp_right_out);
         end
         if (ready_hold == 0) begin
            rsp_ready <= ~rsp_ready;
            if (rsp_ready) begin
               ready_hold = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 3)
                                                        : $urandom_range(4, 40);
            end else begin
               ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 400)
                                                       : $urandom_range(0, 12);
            end
         end else begin
            ready_hold = ready_hold - 1;
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("binaural_matrix_fir verification failed");
            $finish;
         end
      end
   end

   initial begin
      fir_beat_t b;
      int        t;
      int        pick;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // bank one: rail taps, unit weight on the newest tap for the rounding check
      for (t = 0; t < TAP_COUNT; t++) begin
         b = random_beat(ACT_COEF);
         b.tap_index = IDX_W'(t);
         if (t == TAP_COUNT - 1) begin
            b.coef_ll = 16'sd1;
            b.coef_rl = 16'sd0;
            b.coef_rr = 16'sd1;
            b.coef_lr = 16'sd0;
         end else begin
            b.coef_ll = 16'sh7FFF;
            b.coef_rl = 16'sh8000;
            b.coef_rr = 16'sh7FFF;
            b.coef_lr = 16'sh8000;
         end
         push_beat(b);
      end
      swap_banks();
      // bank zero: random taps of mixed range
      for (t = 0; t < TAP_COUNT; t++) begin
         write_tap(IDX_W'(t), pick_span(40, 20));
      end

      // exact half lsb on empty history: left rounds up, right rounds to zero
      play_sample(16'sd8192, -16'sd8192);
      // full scale, positive clamp on left, negative on right
      repeat (6) play_sample(16'sh7FFF, 16'sh8000);
      // and the other way round
      repeat (6) play_sample(16'sh8000, 16'sh7FFF);
      // reserved action leaves history alone
      push_beat(random_beat(ACT_RESERVED));
      play_sample(16'sd0, 16'sd0);
      // back to bank zero
      swap_banks();
      play_sample(-16'sd1, 16'sd1);
      play_sample(draw_value(SPAN_WIDE), draw_value(SPAN_WIDE));
      // first and last tap of bank one rewritten while idle
      write_tap('0, SPAN_RAIL);
      write_tap(IDX_W'(TAP_COUNT - 1), SPAN_NARROW);
      swap_banks();
      play_sample(draw_value(SPAN_RAIL), draw_value(SPAN_NARROW));
      swap_banks();
      play_sample(draw_value(SPAN_NARROW), draw_value(SPAN_NARROW));

      // random traffic, mostly samples
      beats_sent = 0;
      while (beats_sent < RANDOM_BEATS) begin
         if (!drained_once && beats_sent >= RANDOM_BEATS / 2) begin
            wait_for_results();
            drained_once = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            load_bank(pick_span(15, 5));
            swap_banks();
         end else if (pick < 68) begin
            play_sample(draw_value(pick_span(60, 10)), draw_value(pick_span(60, 10)));
         end else if (pick < 86) begin
            write_tap(IDX_W'($urandom), pick_span(30, 10));
         end else if (pick < 94) begin
            swap_banks();
         end else begin
            push_beat(random_beat(ACT_RESERVED));
         end
      end

      // drain and settle
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("binaural_matrix_fir verification clean");
      end else begin
         $display("binaural_matrix_fir verification failed");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/bmf_pkg.sv
rtl/bmf_ram.sv
rtl/bmf_mac.sv
rtl/bmf_seq.sv
rtl/binaural_matrix_fir.sv
rtl/bmf_checker.sv
verif/stereo_fir_check_pkg.sv
verif/binaural_matrix_fir_test.sv
